/* design/nfcrs_pkg.sv */
// ----------------------------------------------------------------------------
// nfcrs_pkg
// Shared types, constants and helpers of the nearest free cell ring search.
// ----------------------------------------------------------------------------
package nfcrs_pkg;

    // grid limits and ring count
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int MAX_RADIUS = 10;

    // field and internal widths
    localparam int IN_W  = 9;                           // cell_x / cell_y ports
    localparam int C_W   = 10;                          // ring coordinates, signed
    localparam int DIM_W = 7;                           // map_width / map_height
    localparam int R_W   = $clog2(MAX_RADIUS + 1);
    localparam int X_BITS = $clog2(MAX_WIDTH);
    localparam int Y_BITS = $clog2(MAX_HEIGHT);
    localparam int MAP_AW = X_BITS + Y_BITS;
    localparam int MAP_DEPTH = 1 << MAP_AW;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [DIM_W-1:0] MAP_WIDTH_RST  = 7'd64;
    localparam logic [DIM_W-1:0] MAP_HEIGHT_RST = 7'd64;

    // register index, taken from paddr[2]
    localparam logic REG_MAP_WIDTH  = 1'b0;
    localparam logic REG_MAP_HEIGHT = 1'b1;

    // command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // result status codes
    localparam logic [1:0] ST_UNCHANGED = 2'd0;
    localparam logic [1:0] ST_MOVED     = 2'd1;
    localparam logic [1:0] ST_FAIL      = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN
    } state_t;

    typedef enum logic [1:0] {
        PH_CENTER,
        PH_ROW,
        PH_COL
    } phase_t;

    typedef struct packed {
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
    } map_size_t;

    typedef struct packed {
        logic load;
        logic advance;
    } ring_ctl_t;

    typedef struct packed {
        logic [C_W-1:0] x;
        logic [C_W-1:0] y;
        logic           in_bounds;
        logic           center;
        logic           last;
    } ring_cand_t;

    // bit C_W-1 is the sign
    function automatic logic in_map(input logic [C_W-1:0] x, input logic [C_W-1:0] y,
                                    input map_size_t sz);
        logic ok_x;
        logic ok_y;
        ok_x = !x[C_W-1] && (x[C_W-2:0] < {{(C_W-1-DIM_W){1'b0}}, sz.w});
        ok_y = !y[C_W-1] && (y[C_W-2:0] < {{(C_W-1-DIM_W){1'b0}}, sz.h});
        return ok_x && ok_y;
    endfunction

    function automatic logic [MAP_AW-1:0] map_addr(input logic [C_W-1:0] x,
                                                   input logic [C_W-1:0] y);
        return {y[Y_BITS-1:0], x[X_BITS-1:0]};
    endfunction

endpackage

/* design/nfcrs_ram.sv */
// ----------------------------------------------------------------------------
// nfcrs_ram
// Generic one-write one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nfcrs_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/nfcrs_regs.sv */
// ----------------------------------------------------------------------------
// nfcrs_regs
// APB register file holding the map size, with clamping to the grid limits.
// ----------------------------------------------------------------------------
module nfcrs_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [nfcrs_pkg::APB_AW-1:0]    paddr,
    input  logic [nfcrs_pkg::APB_DW-1:0]    pwdata,
    output logic [nfcrs_pkg::APB_DW-1:0]    prdata,
    output logic                            pready,
    output nfcrs_pkg::map_size_t            map_size
);

    logic [nfcrs_pkg::DIM_W-1:0] map_width_reg;
    logic [nfcrs_pkg::DIM_W-1:0] map_height_reg;
    logic                        wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg  <= nfcrs_pkg::MAP_WIDTH_RST;
            map_height_reg <= nfcrs_pkg::MAP_HEIGHT_RST;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                nfcrs_pkg::REG_MAP_WIDTH:  map_width_reg  <= pwdata[nfcrs_pkg::DIM_W-1:0];
                nfcrs_pkg::REG_MAP_HEIGHT: map_height_reg <= pwdata[nfcrs_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            nfcrs_pkg::REG_MAP_WIDTH:
                prdata = {{(nfcrs_pkg::APB_DW-nfcrs_pkg::DIM_W){1'b0}}, map_width_reg};
            nfcrs_pkg::REG_MAP_HEIGHT:
                prdata = {{(nfcrs_pkg::APB_DW-nfcrs_pkg::DIM_W){1'b0}}, map_height_reg};
            default:
                prdata = '0;
        endcase
    end

    // sizes above the grid limit act as the limit
    assign map_size.w = ({1'b0, map_width_reg} > (nfcrs_pkg::DIM_W+1)'(nfcrs_pkg::MAX_WIDTH))
                        ? nfcrs_pkg::DIM_W'(nfcrs_pkg::MAX_WIDTH) : map_width_reg;
    assign map_size.h = ({1'b0, map_height_reg} > (nfcrs_pkg::DIM_W+1)'(nfcrs_pkg::MAX_HEIGHT))
                        ? nfcrs_pkg::DIM_W'(nfcrs_pkg::MAX_HEIGHT) : map_height_reg;

endmodule

/* design/nfcrs_ring.sv */
// ----------------------------------------------------------------------------
// nfcrs_ring
// Ring walker: produces one candidate cell per step, centre first, then the
// square rings outwards, with the in-map check of each candidate.
// ----------------------------------------------------------------------------
module nfcrs_ring (
    input  logic                             clk,
    input  logic                             rst_n,
    input  nfcrs_pkg::ring_ctl_t             ctl,
    input  logic signed [nfcrs_pkg::IN_W-1:0] query_x,
    input  logic signed [nfcrs_pkg::IN_W-1:0] query_y,
    input  nfcrs_pkg::map_size_t             map_size,
    output nfcrs_pkg::ring_cand_t            cand
);

    localparam int C_W = nfcrs_pkg::C_W;
    localparam int R_W = nfcrs_pkg::R_W;

    nfcrs_pkg::phase_t phase_reg, phase_next;
    logic             side_reg, side_next;
    logic [R_W-1:0]   radius_reg, radius_next;
    logic [C_W-1:0]   px_reg, px_next;
    logic [C_W-1:0]   py_reg, py_next;
    logic [C_W-1:0]   cur_x_reg, cur_x_next;
    logic [C_W-1:0]   cur_y_reg, cur_y_next;

    logic [C_W-1:0]   rad;
    logic [C_W-1:0]   base;
    logic [C_W-1:0]   edge_pos;
    logic [C_W-1:0]   x_right;
    logic [C_W-1:0]   y_inner_end;
    logic             ring_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= nfcrs_pkg::PH_CENTER;
            side_reg   <= 1'b0;
            radius_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            side_reg   <= side_next;
            radius_reg <= radius_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg    <= px_next;
        py_reg    <= py_next;
        cur_x_reg <= cur_x_next;
        cur_y_reg <= cur_y_next;
    end

    assign rad = {{(C_W-R_W){1'b0}}, radius_reg};

    // shared offset adder: ring edge on the fixed axis of this phase
    assign base     = (phase_reg == nfcrs_pkg::PH_ROW) ? py_reg : px_reg;
    assign edge_pos = side_reg ? (base + rad) : (base - rad);

    assign x_right     = px_reg + rad;
    assign y_inner_end = py_reg + rad - C_W'(1);
    assign ring_end    = (phase_reg == nfcrs_pkg::PH_COL) && side_reg
                         && (cur_y_reg == y_inner_end);

    always_comb
    begin
        case (phase_reg)
            nfcrs_pkg::PH_ROW:
            begin
                cand.x = cur_x_reg;
                cand.y = edge_pos;
            end
            nfcrs_pkg::PH_COL:
            begin
                cand.x = edge_pos;
                cand.y = cur_y_reg;
            end
            default:
            begin
                cand.x = px_reg;
                cand.y = py_reg;
            end
        endcase
        cand.in_bounds = nfcrs_pkg::in_map(cand.x, cand.y, map_size);
        cand.center    = (phase_reg == nfcrs_pkg::PH_CENTER);
        cand.last      = ring_end && (radius_reg == R_W'(nfcrs_pkg::MAX_RADIUS));
    end

    always_comb
    begin
        phase_next  = phase_reg;
        side_next   = side_reg;
        radius_next = radius_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        if (ctl.load)
        begin
            px_next     = {query_x[nfcrs_pkg::IN_W-1], query_x};
            py_next     = {query_y[nfcrs_pkg::IN_W-1], query_y};
            phase_next  = nfcrs_pkg::PH_CENTER;
            side_next   = 1'b0;
            radius_next = '0;
        end
        else if (ctl.advance)
        begin
            case (phase_reg)
                nfcrs_pkg::PH_CENTER:
                begin
                    phase_next  = nfcrs_pkg::PH_ROW;
                    radius_next = R_W'(1);
                    cur_x_next  = px_reg - C_W'(1);
                    side_next   = 1'b0;
                end
                nfcrs_pkg::PH_ROW:
                begin
                    side_next = !side_reg;
                    if (side_reg)
                    begin
                        if (cur_x_reg == x_right)
                        begin
                            phase_next = nfcrs_pkg::PH_COL;
                            cur_y_next = py_reg - rad + C_W'(1);
                        end
                        else
                        begin
                            cur_x_next = cur_x_reg + C_W'(1);
                        end
                    end
                end
                nfcrs_pkg::PH_COL:
                begin
                    side_next = !side_reg;
                    if (ring_end)
                    begin
                        phase_next  = nfcrs_pkg::PH_ROW;
                        radius_next = radius_reg + R_W'(1);
                        cur_x_next  = px_reg - rad - C_W'(1);
                    end
                    else if (side_reg)
                    begin
                        cur_y_next = cur_y_reg + C_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

/* design/nearest_free_cell_ring_search.sv */
// ----------------------------------------------------------------------------
// nearest_free_cell_ring_search
// Obstacle bitmap with a nearest free cell search over square rings.
// ----------------------------------------------------------------------------
//  channel   signals                                       direction  handshake
//  request   start command cell_x cell_y obstacle / busy   in         start && !busy
//  result    done status found_x found_y                   out        done, one cycle
//  config    psel penable pwrite paddr pwdata prdata pready in        apb, pready high
//
//  a write request is taken while idle and busy never rises for it
//  a query keeps busy while it walks k ring cells, or ends at the centre when that is outside the map
//  (k at most 4 * MAX_RADIUS * (MAX_RADIUS + 1), 440 here); done rises as busy falls
//  one map cell is read per cycle through the single read port of the map RAM
//  reset clears the control state only; the map is undefined until written
//  the result is held for one cycle and the receiver cannot stall it
// ----------------------------------------------------------------------------
module nearest_free_cell_ring_search (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             command,
    input  logic signed [nfcrs_pkg::IN_W-1:0] cell_x,
    input  logic signed [nfcrs_pkg::IN_W-1:0] cell_y,
    input  logic                             obstacle,
    output logic                             done,
    output logic [1:0]                       status,
    output logic signed [nfcrs_pkg::IN_W-1:0] found_x,
    output logic signed [nfcrs_pkg::IN_W-1:0] found_y,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [nfcrs_pkg::APB_AW-1:0]     paddr,
    input  logic [nfcrs_pkg::APB_DW-1:0]     pwdata,
    output logic [nfcrs_pkg::APB_DW-1:0]     prdata,
    output logic                             pready
);

    localparam int C_W  = nfcrs_pkg::C_W;
    localparam int IN_W = nfcrs_pkg::IN_W;

    nfcrs_pkg::state_t     state_reg, state_next;
    nfcrs_pkg::map_size_t  map_size;
    nfcrs_pkg::ring_ctl_t  ring_ctl;
    nfcrs_pkg::ring_cand_t cand;

    logic                  pend_valid_reg, pend_valid_next;
    logic                  pend_inside_reg, pend_inside_next;
    logic                  pend_center_reg, pend_center_next;
    logic [C_W-1:0]        pend_x_reg, pend_x_next;
    logic [C_W-1:0]        pend_y_reg, pend_y_next;

    logic                  done_reg, done_next;
    logic [1:0]            status_reg, status_next;
    logic [IN_W-1:0]       found_x_reg, found_x_next;
    logic [IN_W-1:0]       found_y_reg, found_y_next;

    logic                  accept;
    logic                  query_acc;
    logic [C_W-1:0]        wr_x;
    logic [C_W-1:0]        wr_y;
    logic                  ram_we;
    logic [nfcrs_pkg::MAP_AW-1:0] ram_waddr;
    logic [nfcrs_pkg::MAP_AW-1:0] ram_raddr;
    logic                  ram_rdata;
    logic                  hit;
    logic                  center_fail;

    nfcrs_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .map_size (map_size)
    );

    nfcrs_ring u_ring (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ring_ctl),
        .query_x  (cell_x),
        .query_y  (cell_y),
        .map_size (map_size),
        .cand     (cand)
    );

    nfcrs_ram #(
        .WIDTH (1),
        .DEPTH (nfcrs_pkg::MAP_DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (obstacle),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign busy      = (state_reg != nfcrs_pkg::S_IDLE);
    assign accept    = start && !busy;
    assign query_acc = accept && (command == nfcrs_pkg::CMD_QUERY);

    // writes outside the map in use are dropped
    assign wr_x      = {cell_x[IN_W-1], cell_x};
    assign wr_y      = {cell_y[IN_W-1], cell_y};
    assign ram_we    = accept && (command == nfcrs_pkg::CMD_WRITE)
                       && nfcrs_pkg::in_map(wr_x, wr_y, map_size);
    assign ram_waddr = nfcrs_pkg::map_addr(wr_x, wr_y);
    assign ram_raddr = nfcrs_pkg::map_addr(cand.x, cand.y);

    // read data belongs to the candidate held in the pending stage
    assign hit         = pend_valid_reg && pend_inside_reg && !ram_rdata;
    assign center_fail = (state_reg == nfcrs_pkg::S_SCAN) && cand.center && !cand.in_bounds;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= nfcrs_pkg::S_IDLE;
            pend_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_inside_reg <= pend_inside_next;
        pend_center_reg <= pend_center_next;
        pend_x_reg      <= pend_x_next;
        pend_y_reg      <= pend_y_next;
        status_reg      <= status_next;
        found_x_reg     <= found_x_next;
        found_y_reg     <= found_y_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nfcrs_pkg::S_IDLE:
            begin
                if (query_acc)
                begin
                    state_next = nfcrs_pkg::S_SCAN;
                end
            end
            nfcrs_pkg::S_SCAN:
            begin
                if (hit || center_fail)
                begin
                    state_next = nfcrs_pkg::S_IDLE;
                end
                else if (cand.last)
                begin
                    state_next = nfcrs_pkg::S_DRAIN;
                end
            end
            nfcrs_pkg::S_DRAIN:
            begin
                state_next = nfcrs_pkg::S_IDLE;
            end
            default:
            begin
                state_next = nfcrs_pkg::S_IDLE;
            end
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        ring_ctl.load    = query_acc;
        ring_ctl.advance = 1'b0;
        pend_valid_next  = 1'b0;
        pend_inside_next = cand.in_bounds;
        pend_center_next = cand.center;
        pend_x_next      = cand.x;
        pend_y_next      = cand.y;
        done_next        = 1'b0;
        status_next      = nfcrs_pkg::ST_FAIL;
        found_x_next     = '0;
        found_y_next     = '0;
        case (state_reg)
            nfcrs_pkg::S_SCAN:
            begin
                ring_ctl.advance = !hit && !center_fail;
                pend_valid_next  = !hit && !center_fail;
                if (hit)
                begin
                    done_next    = 1'b1;
                    status_next  = pend_center_reg ? nfcrs_pkg::ST_UNCHANGED
                                                   : nfcrs_pkg::ST_MOVED;
                    found_x_next = pend_x_reg[IN_W-1:0];
                    found_y_next = pend_y_reg[IN_W-1:0];
                end
                else if (center_fail)
                begin
                    done_next = 1'b1;
                end
            end
            nfcrs_pkg::S_DRAIN:
            begin
                done_next = 1'b1;
                if (hit)
                begin
                    status_next  = pend_center_reg ? nfcrs_pkg::ST_UNCHANGED
                                                   : nfcrs_pkg::ST_MOVED;
                    found_x_next = pend_x_reg[IN_W-1:0];
                    found_y_next = pend_y_reg[IN_W-1:0];
                end
            end
            default: ;
        endcase
    end

    assign done    = done_reg;
    assign status  = status_reg;
    assign found_x = found_x_reg;
    assign found_y = found_y_reg;

`ifndef SYNTHESIS
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (command == nfcrs_pkg::CMD_QUERY)) |=> busy)
        else $error("query request taken without going busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a query in progress");

    a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !busy)
        else $error("map written during a search");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == nfcrs_pkg::ST_FAIL)) |-> (found_x == '0) && (found_y == '0))
        else $error("failed search with non-zero cell");
`endif

endmodule
